// ===== design/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

   localparam int MAX_PATTERN_DEFAULT  = 16;
   localparam int ADDRESS_BITS_DEFAULT = 32;

   localparam int CFG_PATTERN_BYTES = 16;
   localparam int ADDR_FIELD_BITS   = 32;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_WILDCARD     = 3'd2,
      CSR_LENGTH       = 3'd3,
      CSR_ZERO_WILD    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0]                 data_byte;
      logic [ADDR_FIELD_BITS-1:0] byte_address;
      logic                       section_first;
      logic                       scan_first;
      logic                       scan_last;
   } req_data_type;

   typedef struct packed {
      logic                       found;
      logic [ADDR_FIELD_BITS-1:0] match_address;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== design/wbps_csr.sv =====
// ----------------------------------------------------------------------------
// wbps_csr
// Configuration registers and the pattern aligned to the byte window.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_csr #(
   parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     csr_wr_en,
   input  wire logic [wbps_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire logic [wbps_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   output logic      [MAX_PATTERN-1:0][7:0]              aligned_ff,
   output logic      [MAX_PATTERN-1:0]                   care_ff,
   output logic      [$clog2(MAX_PATTERN+1)-1:0]         len_ff,
   output logic      [$clog2(MAX_PATTERN+1)-1:0]         len_m1_ff
);

   localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
   localparam int JW       = (LEN_BITS > 5) ? LEN_BITS : 5;

   logic [63:0]          pat_low_ff;
   logic [63:0]          pat_high_ff;
   logic [15:0]          mask_ff;
   logic [4:0]           len_cfg_ff;
   logic                 zero_wild_ff;
   logic [127:0]         pat_all;
   logic [LEN_BITS-1:0]  len_sat;
   logic [MAX_PATTERN-1:0][JW-1:0] jpos;
   logic [MAX_PATTERN-1:0][7:0]    pbyte;
   logic [MAX_PATTERN-1:0][7:0]    aligned_in;
   logic [MAX_PATTERN-1:0]         care_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         mask_ff      <= '0;
         len_cfg_ff   <= 5'd1;
         zero_wild_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (wbps_pkg::csr_index_type'(csr_index))
            wbps_pkg::CSR_PATTERN_LOW:  pat_low_ff   <= csr_wdata;
            wbps_pkg::CSR_PATTERN_HIGH: pat_high_ff  <= csr_wdata;
            wbps_pkg::CSR_WILDCARD:     mask_ff      <= csr_wdata[15:0];
            wbps_pkg::CSR_LENGTH:       len_cfg_ff   <= csr_wdata[4:0];
            wbps_pkg::CSR_ZERO_WILD:    zero_wild_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign pat_all = {pat_high_ff, pat_low_ff};

   always_comb begin
      if (len_cfg_ff == 5'd0) begin
         len_sat = LEN_BITS'(1);
      end else if (int'(len_cfg_ff) > MAX_PATTERN) begin
         len_sat = LEN_BITS'(MAX_PATTERN);
      end else begin
         len_sat = LEN_BITS'(len_cfg_ff);
      end
   end

   // window slot k holds pattern byte (len - 1 - k)
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         jpos[k] = JW'(len_sat) - JW'(k) - JW'(1);
         if (jpos[k] < JW'(wbps_pkg::CFG_PATTERN_BYTES)) begin
            pbyte[k] = pat_all[{jpos[k][3:0], 3'b000} +: 8];
         end else begin
            pbyte[k] = 8'h00;
         end
         if (JW'(k) < JW'(len_sat)) begin
            aligned_in[k] = pbyte[k];
            care_in[k]    = !((jpos[k] < JW'(wbps_pkg::CFG_PATTERN_BYTES) &&
                               mask_ff[jpos[k][3:0]]) ||
                              (zero_wild_ff && pbyte[k] == 8'h00));
         end else begin
            aligned_in[k] = 8'h00;
            care_in[k]    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      aligned_ff <= aligned_in;
      care_ff    <= care_in;
      len_ff     <= len_sat;
      len_m1_ff  <= len_sat - LEN_BITS'(1);
   end

endmodule

`default_nettype wire

// ===== design/wbps_window.sv =====
// ----------------------------------------------------------------------------
// wbps_window
// Shift window of the newest bytes of the current section and its fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_window #(
   parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              shift_en,
   input  wire wbps_pkg::req_data_type            req_data,
   output logic      [MAX_PATTERN-1:0][7:0]       window_ff,
   output logic      [$clog2(MAX_PATTERN+1)-1:0]  fill_ff
);

   localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);

   logic [LEN_BITS-1:0] fill_base;
   logic [LEN_BITS-1:0] fill_in;

   always_comb begin
      fill_base = req_data.section_first ? '0 : fill_ff;
      if (int'(fill_base) < MAX_PATTERN) begin
         fill_in = fill_base + LEN_BITS'(1);
      end else begin
         fill_in = fill_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (shift_en) begin
         fill_ff <= fill_in;
      end
   end

   // newest byte in slot 0
   always_ff @(posedge clock) begin
      if (shift_en) begin
         window_ff[0] <= req_data.data_byte;
         for (int k = 1; k < MAX_PATTERN; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/wbps_match.sv =====
// ----------------------------------------------------------------------------
// wbps_match
// Window compare, first-match tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_match #(
   parameter int MAX_PATTERN  = wbps_pkg::MAX_PATTERN_DEFAULT,
   parameter int ADDRESS_BITS = wbps_pkg::ADDRESS_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              item_load,
   input  wire wbps_pkg::req_data_type            req_data,
   output logic                                   stage_ready,
   input  wire logic [MAX_PATTERN-1:0][7:0]       window_ff,
   input  wire logic [$clog2(MAX_PATTERN+1)-1:0]  fill_ff,
   input  wire logic [MAX_PATTERN-1:0][7:0]       aligned_ff,
   input  wire logic [MAX_PATTERN-1:0]            care_ff,
   input  wire logic [$clog2(MAX_PATTERN+1)-1:0]  len_ff,
   input  wire logic [$clog2(MAX_PATTERN+1)-1:0]  len_m1_ff,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output wbps_pkg::rsp_data_type                 rsp_data
);

   logic                    s1_valid_ff;
   logic [ADDRESS_BITS-1:0] s1_addr_ff;
   logic                    s1_scan_first_ff;
   logic                    s1_scan_last_ff;
   logic                    reported_ff;
   logic                    rsp_valid_ff;
   wbps_pkg::rsp_data_type  rsp_data_ff;
   wbps_pkg::rsp_data_type  rsp_data_in;

   logic [MAX_PATTERN-1:0]  slot_ok;
   logic                    hit;
   logic                    reported_now;
   logic                    emit;
   logic                    out_free;
   logic                    s1_adv;
   logic [ADDRESS_BITS-1:0] start_addr;

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         slot_ok[k] = !care_ff[k] || (window_ff[k] == aligned_ff[k]);
      end
   end

   assign hit          = (fill_ff >= len_ff) && (&slot_ok);
   assign reported_now = s1_scan_first_ff ? 1'b0 : reported_ff;
   assign emit         = s1_valid_ff && !reported_now && (hit || s1_scan_last_ff);
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign s1_adv       = s1_valid_ff && (!emit || out_free);
   assign stage_ready  = !s1_valid_ff || s1_adv;
   assign start_addr   = s1_addr_ff - ADDRESS_BITS'(len_m1_ff);

   always_comb begin
      rsp_data_in.found = hit;
      if (hit) begin
         rsp_data_in.match_address = wbps_pkg::ADDR_FIELD_BITS'(start_addr);
      end else begin
         rsp_data_in.match_address = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            reported_ff <= reported_now || emit;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_adv && emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_load) begin
         s1_addr_ff       <= ADDRESS_BITS'(req_data.byte_address);
         s1_scan_first_ff <= req_data.scan_first;
         s1_scan_last_ff  <= req_data.scan_last;
      end
      if (s1_adv && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_not_found_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found |-> rsp_data_ff.match_address == '0)
      else $error("not-found item carries an address");

   a_reported_set : assert property (@(posedge clock) disable iff (reset)
      s1_adv && emit |=> reported_ff)
      else $error("result sent without marking scan reported");

   a_single_result : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && reported_ff && !s1_scan_first_ff |-> !emit)
      else $error("second result within one scan");

   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("stalled item lost from compare stage");

endmodule

`default_nettype wire

// ===== design/wildcard_byte_pattern_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_unit
// Streams image bytes through a window and reports the first match of a
// wildcard byte pattern per scan.
//
// Usage:
//   req_*  : one image byte per item with its address and section/scan flags.
//   rsp_*  : at most one item per scan: found with the match start address,
//            or not-found (address zero) on the last byte of the scan.
//   csr_*  : pattern, wildcard mask, length and zero-wildcard mode; write
//            only while no item is in flight.
// Timing:
//   One byte per cycle sustained unless a held result stalls the compare
//   stage. A result passes the window and compare register, then the result
//   register. After each configuration write the pattern is realigned to the
//   window in a register that follows the configuration registers.
// Reset clears the window fill count, the scan state and the valid flags,
// and loads the register reset values (length one).
// When rsp_ready is low the result register holds; bytes without a result
// keep flowing, the next byte that carries a result waits in the compare
// stage, and req_ready stays low until the held result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scanner_unit #(
   parameter int MAX_PATTERN  = wbps_pkg::MAX_PATTERN_DEFAULT,
   parameter int ADDRESS_BITS = wbps_pkg::ADDRESS_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire wbps_pkg::req_data_type              req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output wbps_pkg::rsp_data_type                   rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [wbps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [wbps_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);

   logic                          req_accept;
   logic                          stage_ready;
   logic [MAX_PATTERN-1:0][7:0]   aligned;
   logic [MAX_PATTERN-1:0]        care;
   logic [LEN_BITS-1:0]           len;
   logic [LEN_BITS-1:0]           len_m1;
   logic [MAX_PATTERN-1:0][7:0]   window;
   logic [LEN_BITS-1:0]           fill;

   assign req_ready  = stage_ready;
   assign req_accept = req_valid && stage_ready;

   wbps_csr #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .aligned_ff (aligned),
      .care_ff    (care),
      .len_ff     (len),
      .len_m1_ff  (len_m1)
   );

   wbps_window #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (req_accept),
      .req_data  (req_data),
      .window_ff (window),
      .fill_ff   (fill)
   );

   wbps_match #(
      .MAX_PATTERN  (MAX_PATTERN),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_match (
      .clock       (clock),
      .reset       (reset),
      .item_load   (req_accept),
      .req_data    (req_data),
      .stage_ready (stage_ready),
      .window_ff   (window),
      .fill_ff     (fill),
      .aligned_ff  (aligned),
      .care_ff     (care),
      .len_ff      (len),
      .len_m1_ff   (len_m1),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== verif/wildcard_byte_pattern_scanner_unit_tb.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_unit_tb
// Streams image bytes through the scanner under random handshake gaps and
// checks every found / not-found item against an in-bench scan predictor.
// Directed scans cover register defaults, address wrap, wildcard modes,
// section and scan boundaries and length limits. Random phases then
// reprogram the pattern and send scans with planted matches plus noise.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scanner_unit_tb;

   localparam int          PATTERN_DEPTH   = wbps_pkg::MAX_PATTERN_DEFAULT;
   localparam int          CSR_SPARE_FIRST = 5;
   localparam int          CSR_SPARE_LAST  = 7;
   localparam int          BYTE_TARGET     = 850;
   localparam int          PHASE_BYTES     = 70;
   localparam int          DRAIN_CYCLES    = 4;
   localparam int          QUIET_LIMIT     = 2000;

   logic                                  clock     = 1'b0;
   logic                                  reset     = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   wbps_pkg::req_data_type                req_data  = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   wbps_pkg::rsp_data_type                rsp_data;
   logic                                  csr_wr_en = 1'b0;
   logic [wbps_pkg::CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [wbps_pkg::CSR_DATA_BITS-1:0]    csr_wdata = '0;

   // scan predictor state and register shadow
   logic [7:0]                  recent_bytes [PATTERN_DEPTH];
   int unsigned                 recent_count;
   bit                          scan_answered;
   logic [63:0]                 pattern_lo;
   logic [63:0]                 pattern_hi;
   logic [15:0]                 any_mask;
   logic [4:0]                  pattern_len_reg;
   logic                        zero_any;

   wbps_pkg::rsp_data_type      pending_outcomes [$];
   int unsigned                 bytes_sent;
   int unsigned                 mismatch_count;
   int unsigned                 quiet_cycles;
   bit                          req_steady;
   bit                          rsp_steady;

   wildcard_byte_pattern_scanner_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned used_length();
      if (pattern_len_reg == 5'd0) return 1;
      if (pattern_len_reg > PATTERN_DEPTH) return PATTERN_DEPTH;
      return pattern_len_reg;
   endfunction

   function automatic logic [7:0] pattern_at(input int unsigned j);
      logic [127:0] all_bytes;
      all_bytes = {pattern_hi, pattern_lo};
      return all_bytes[8*j +: 8];
   endfunction

   function automatic bit wild_at(input int unsigned j);
      return any_mask[j] || (zero_any && pattern_at(j) == 8'h00);
   endfunction

   function automatic void predict_scan_step(input wbps_pkg::req_data_type item);
      int unsigned            len;
      bit                     hit;
      wbps_pkg::rsp_data_type outcome;
      if (item.section_first) recent_count = 0;
      if (item.scan_first) scan_answered = 1'b0;
      for (int k = PATTERN_DEPTH - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = item.data_byte;
      if (recent_count < PATTERN_DEPTH) recent_count++;
      len = used_length();
      hit = (recent_count >= len);
      for (int j = 0; j < len; j++) begin
         if (!wild_at(j) && pattern_at(j) != recent_bytes[len-1-j]) hit = 1'b0;
      end
      if (scan_answered) return;
      if (hit) begin
         scan_answered = 1'b1;
         outcome.found = 1'b1;
         outcome.match_address = item.byte_address - 32'(len - 1);
         pending_outcomes = {pending_outcomes, outcome};
      end else if (item.scan_last) begin
         scan_answered = 1'b1;
         outcome.found = 1'b0;
         outcome.match_address = '0;
         pending_outcomes = {pending_outcomes, outcome};
      end
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("result mismatch: %s", msg);
   endtask

   task automatic send_byte(input logic [7:0] d, input logic [31:0] a,
                            input logic sec, input logic first, input logic last);
      int unsigned            gap;
      wbps_pkg::req_data_type item;
      item.data_byte     = d;
      item.byte_address  = a;
      item.section_first = sec;
      item.scan_first    = first;
      item.scan_last     = last;
      gap = req_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_scan_step(item);
      bytes_sent++;
   endtask

   // drop valid, drain results, let in-flight bytes settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [wbps_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [wbps_pkg::CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         wbps_pkg::CSR_PATTERN_LOW:  pattern_lo = value;
         wbps_pkg::CSR_PATTERN_HIGH: pattern_hi = value;
         wbps_pkg::CSR_WILDCARD:     any_mask = value[15:0];
         wbps_pkg::CSR_LENGTH:       pattern_len_reg = value[4:0];
         wbps_pkg::CSR_ZERO_WILD:    zero_any = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [63:0] mask, input logic [63:0] len,
                            input logic [63:0] zero_mode, input bit spares);
      write_csr(wbps_pkg::CSR_PATTERN_LOW, lo);
      write_csr(wbps_pkg::CSR_PATTERN_HIGH, hi);
      write_csr(wbps_pkg::CSR_WILDCARD, mask);
      write_csr(wbps_pkg::CSR_LENGTH, len);
      write_csr(wbps_pkg::CSR_ZERO_WILD, zero_mode);
      if (spares) begin
         for (int s = CSR_SPARE_FIRST; s <= CSR_SPARE_LAST; s++)
            write_csr(3'(s), {$urandom, $urandom});
      end
      csr_wr_en <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      // length one, pattern byte zero, no wildcards
      send_byte(8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_wrap_and_last_byte();
      // pattern AA, any, zero-as-wild, 55
      wait_idle();
      configure(64'h0000_0000_5500_3CAA, '1, 64'h2, 64'd4, 64'd1, 1'b0);
      send_byte(8'hAA, 32'hFFFF_FFFE, 1'b1, 1'b1, 1'b0);
      send_byte(8'h13, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
      send_byte(8'h77, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
      send_byte(8'h55, 32'h0000_0001, 1'b0, 1'b0, 1'b1);
   endtask

   task automatic test_scan_and_section_rules();
      send_byte(8'hAA, 32'h100, 1'b1, 1'b1, 1'b0);
      send_byte(8'h11, 32'h101, 1'b0, 1'b0, 1'b1);
      // new scan keeps the window
      send_byte(8'h22, 32'h102, 1'b0, 1'b1, 1'b0);
      send_byte(8'h55, 32'h103, 1'b0, 1'b0, 1'b0);
      send_byte(8'hAA, 32'h104, 1'b0, 1'b0, 1'b1);
      // section start clears the window
      send_byte(8'hAA, 32'h200, 1'b1, 1'b1, 1'b0);
      send_byte(8'h11, 32'h300, 1'b1, 1'b0, 1'b0);
      send_byte(8'h22, 32'h301, 1'b0, 1'b0, 1'b0);
      send_byte(8'h55, 32'h302, 1'b0, 1'b0, 1'b1);
   endtask

   task automatic test_length_limits();
      wait_idle();
      configure(64'h5A, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1);
      send_byte(8'h5A, 32'h0, 1'b1, 1'b1, 1'b1);
      wait_idle();
      configure(64'h0, 64'h0, 64'h0, '1, 64'h1, 1'b0);
      for (int j = 0; j < PATTERN_DEPTH; j++)
         send_byte(8'(j * 17), 32'h8000_0000 + j, j == 0, j == 0, j == PATTERN_DEPTH - 1);
   endtask

   task automatic send_scan();
      int unsigned sections;
      int unsigned sec_len;
      int unsigned plen;
      int unsigned spot;
      logic [31:0] addr;
      logic [7:0]  d;
      bit          first_of_scan;
      bit          plant;
      bit          keep_window;
      bit          drop_last;
      sections    = $urandom_range(1, 3);
      first_of_scan = 1'b1;
      keep_window = ($urandom_range(0, 4) == 0);
      drop_last   = ($urandom_range(0, 9) == 0);
      plen        = used_length();
      for (int k = 0; k < sections; k++) begin
         sec_len = $urandom_range(1, 24);
         addr    = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20)
                                               : $urandom;
         plant   = $urandom_range(0, 1) && sec_len >= plen;
         spot    = plant ? $urandom_range(0, sec_len - plen) : 0;
         for (int j = 0; j < sec_len; j++) begin
            if (plant && j >= spot && j < spot + plen)
               d = wild_at(j - spot) ? 8'($urandom) : pattern_at(j - spot);
            else
               d = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
            send_byte(d, addr, (j == 0) && !(k == 0 && keep_window), first_of_scan,
                      (k == sections - 1) && (j == sec_len - 1) && !drop_last);
            first_of_scan = 1'b0;
            addr++;
         end
      end
   endtask

   task automatic test_random_scans();
      int unsigned  phase;
      int unsigned  phase_start;
      int unsigned  r;
      int unsigned  len;
      logic [127:0] pbytes;
      logic [63:0]  mask_word;
      logic [63:0]  len_word;
      logic [63:0]  zero_word;
      phase = 0;
      while (bytes_sent < BYTE_TARGET) begin
         wait_idle();
         case (phase)
            0: configure(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0);
            1: configure('1, '1, '1, '1, '1, 1'b1);
            2: configure('1, '1, 64'h0, 64'd16, 64'h0, 1'b0);
            default: begin
               for (int j = 0; j < PATTERN_DEPTH; j++) begin
                  r = $urandom_range(0, 3);
                  pbytes[8*j +: 8] = (r == 0) ? 8'h00 :
                                     (r == 1) ? 8'($urandom_range(1, 3)) : 8'($urandom);
               end
               mask_word = {$urandom, $urandom};
               mask_word[15:0] = ($urandom_range(0, 3) == 0) ? 16'h0
                                                             : 16'($urandom & $urandom);
               r = $urandom_range(0, 9);
               if (r == 0) len = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
               else if (r == 1) len = PATTERN_DEPTH;
               else len = $urandom_range(1, 6);
               len_word = {$urandom, $urandom};
               len_word[4:0] = 5'(len);
               zero_word = {$urandom, $urandom};
               zero_word[0] = 1'($urandom);
               configure(pbytes[63:0], pbytes[127:64], mask_word, len_word, zero_word,
                         $urandom_range(0, 3) == 0);
            end
         endcase
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            if ($urandom_range(0, 6) == 0) begin
               repeat ($urandom_range(1, 5))
                  send_byte(8'($urandom), $urandom, 1'($urandom), 1'($urandom),
                            1'($urandom));
            end else begin
               send_scan();
            end
         end
         phase++;
      end
   endtask

   initial begin : rsp_side
      int unsigned            stall;
      wbps_pkg::rsp_data_type want;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected item found=%0b address=%h",
                                      rsp_data.found, rsp_data.match_address));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found expected %0b actual %0b",
                                         want.found, rsp_data.found));
            if (rsp_data.match_address !== want.match_address)
               report_mismatch($sformatf("match_address expected %h actual %h",
                                         want.match_address, rsp_data.match_address));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      for (int k = 0; k < PATTERN_DEPTH; k++) recent_bytes[k] = 8'h00;
      recent_count      = 0;
      scan_answered     = 1'b0;
      pattern_lo        = '0;
      pattern_hi        = '0;
      any_mask          = '0;
      pattern_len_reg   = 5'd1;
      zero_any          = 1'b0;
      bytes_sent        = 0;
      mismatch_count    = 0;
      req_steady        = 1'b0;
      rsp_steady        = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_wrap_and_last_byte();
      test_scan_and_section_rules();
      test_length_limits();
      test_random_scans();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

// ===== wildcard_byte_pattern_scanner_unit.f =====
design/wbps_pkg.sv
design/wbps_csr.sv
design/wbps_window.sv
design/wbps_match.sv
design/wildcard_byte_pattern_scanner_unit.sv
verif/wildcard_byte_pattern_scanner_unit_tb.sv
